// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros: clocked concurrent checks, disabled while the active-low reset is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ESC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be seen outside reset
`define ESC_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- rtl/esc_pkg.sv -----
// ----------------------------------------------------------------------------
// esc_pkg
// Shared codes, constants and helpers of the sensor compensation unit.
// ----------------------------------------------------------------------------
package esc_pkg;

    localparam int unsigned OP_W   = 2;
    localparam int unsigned RAW_W  = 20;
    localparam int unsigned RES_W  = 32;
    localparam int unsigned CIDX_W = 3;
    localparam int unsigned CDAT_W = 64;

    // reading kinds
    localparam logic [OP_W-1:0] OP_TEMP  = 2'd0;
    localparam logic [OP_W-1:0] OP_PRESS = 2'd1;
    localparam logic [OP_W-1:0] OP_HUM   = 2'd2;

    // calibration register indexes
    localparam logic [CIDX_W-1:0] CFG_CAL_TEMP    = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_CAL_PRESS_A = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_CAL_PRESS_B = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_CAL_PRESS_C = 3'd3;
    localparam logic [CIDX_W-1:0] CFG_CAL_HUM_A   = 3'd4;
    localparam logic [CIDX_W-1:0] CFG_CAL_HUM_B   = 3'd5;

    // compensation constants
    localparam logic signed [63:0] C_P_TOFS  = 64'sd128000;
    localparam logic signed [63:0] C_P_ADC   = 64'sd1048576;
    localparam logic signed [63:0] C_P_SCALE = 64'sd3125;
    localparam logic signed [63:0] C_P_BIAS  = 64'sh0000_8000_0000_0000;
    localparam logic signed [63:0] C_H_TOFS  = 64'sd76800;
    localparam logic signed [63:0] C_H_RND1  = 64'sd16384;
    localparam logic signed [63:0] C_H_OFS2  = 64'sd32768;
    localparam logic signed [63:0] C_H_OFS3  = 64'sd2097152;
    localparam logic signed [63:0] C_H_RND2  = 64'sd8192;
    localparam logic signed [63:0] C_H_MAX   = 64'sd419430400;
    localparam logic signed [63:0] C_T_RND   = 64'sd128;
    localparam logic signed [63:0] C_T_SCALE = 64'sd5;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_RUN  = 5'b00010,
        S_MUL  = 5'b00100,
        S_DIV  = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    function automatic logic signed [63:0] sx32(input logic [63:0] v);
        return {{32{v[31]}}, v[31:0]};
    endfunction

    function automatic logic signed [63:0] sx16(input logic [15:0] v);
        return {{48{v[15]}}, v};
    endfunction

    function automatic logic signed [63:0] sx8(input logic [7:0] v);
        return {{56{v[7]}}, v};
    endfunction

endpackage

// ----- rtl/esc_if.sv -----
// ----------------------------------------------------------------------------
// esc channel interfaces
// Valid/ready channels for readings, results and calibration writes.
// ----------------------------------------------------------------------------
interface esc_in_if;
    logic                         valid;
    logic                         ready;
    logic [esc_pkg::OP_W-1:0]     op;
    logic [esc_pkg::RAW_W-1:0]    raw_reading;
    modport source (output valid, output op, output raw_reading, input ready);
    modport sink   (input valid, input op, input raw_reading, output ready);
endinterface

interface esc_out_if;
    logic                         valid;
    logic                         ready;
    logic [esc_pkg::OP_W-1:0]     kind;
    logic signed [esc_pkg::RES_W-1:0] compensated;
    modport source (output valid, output kind, output compensated, input ready);
    modport sink   (input valid, input kind, input compensated, output ready);
endinterface

interface esc_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [esc_pkg::CIDX_W-1:0]   index;
    logic [esc_pkg::CDAT_W-1:0]   data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/env_sensor_compensation_unit.sv -----
// ----------------------------------------------------------------------------
// env_sensor_compensation_unit
// Integer compensation of temperature, pressure and humidity readings.
//
// Channels: i_in carries one reading (op, raw_reading); o_res returns one
// transaction per reading (kind, compensated); i_cfg writes calibration
// registers 0..5 (higher indexes are dropped) and is always ready. Write it
// only while no reading is in flight.
// A single 32x32 multiplier builds every 64-bit product from three partial
// products; a restoring divider serves the pressure division. One reading
// is processed at a time, and i_in.ready is high only while idle.
// Reset clears the calibration registers, the stored fine temperature and
// the sequencer. If the receiver stalls, the result holds in its output
// register and no new reading is taken until the transaction completes.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module env_sensor_compensation_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    esc_cfg_if.sink   i_cfg,
    esc_in_if.sink    i_in,
    esc_out_if.source o_res
);

    // calibration registers
    logic [47:0] r_cal_temp;
    logic [63:0] r_cal_press_a;
    logic [63:0] r_cal_press_b;
    logic [15:0] r_cal_press_c;
    logic [39:0] r_cal_hum_a;
    logic [31:0] r_cal_hum_b;

    // stored fine temperature, used by pressure and humidity
    logic [31:0] r_fine, n_fine;

    // sequencer
    esc_pkg::t_state r_state, n_state;
    logic [3:0]  r_pc, n_pc;
    logic [esc_pkg::OP_W-1:0]  r_op, n_op;
    logic [esc_pkg::RAW_W-1:0] r_adc, n_adc;
    logic [esc_pkg::RES_W-1:0] r_res, n_res;

    // working registers
    logic signed [63:0] r_x, n_x;
    logic signed [63:0] r_v1, n_v1;
    logic signed [63:0] r_v2, n_v2;
    logic signed [63:0] r_w, n_w;

    // shared multiplier: 64x64 low product from three 32x32 partials
    logic [63:0] r_ma, n_ma;
    logic [63:0] r_mb, n_mb;
    logic signed [63:0] r_mp, n_mp;
    logic [1:0]  r_mph, n_mph;

    // restoring divider on magnitudes
    logic [63:0] r_rem, n_rem;
    logic [63:0] r_quo, n_quo;
    logic [63:0] r_den, n_den;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_qneg, n_qneg;

    logic        in_acc;
    logic        out_acc;

    assign in_acc  = i_in.valid && i_in.ready;
    assign out_acc = o_res.valid && o_res.ready;

    assign i_in.ready        = (r_state == esc_pkg::S_IDLE);
    assign i_cfg.ready       = 1'b1;
    assign o_res.valid       = (r_state == esc_pkg::S_DONE);
    assign o_res.kind        = r_op;
    assign o_res.compensated = r_res;

    // calibration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_temp    <= '0;
            r_cal_press_a <= '0;
            r_cal_press_b <= '0;
            r_cal_press_c <= '0;
            r_cal_hum_a   <= '0;
            r_cal_hum_b   <= '0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.index)
                esc_pkg::CFG_CAL_TEMP:    r_cal_temp    <= i_cfg.data[47:0];
                esc_pkg::CFG_CAL_PRESS_A: r_cal_press_a <= i_cfg.data;
                esc_pkg::CFG_CAL_PRESS_B: r_cal_press_b <= i_cfg.data;
                esc_pkg::CFG_CAL_PRESS_C: r_cal_press_c <= i_cfg.data[15:0];
                esc_pkg::CFG_CAL_HUM_A:   r_cal_hum_a   <= i_cfg.data[39:0];
                esc_pkg::CFG_CAL_HUM_B:   r_cal_hum_b   <= i_cfg.data[31:0];
                default: ;
            endcase
        end
    end

    // next-state logic: one program step, multiplier phase or divider bit per cycle
    always_comb begin
        logic               go_mul;
        logic               go_done;
        logic signed [63:0] ma_v;
        logic signed [63:0] mb_v;
        logic signed [63:0] res_v;
        logic signed [63:0] adc;
        logic signed [63:0] tf;
        logic signed [63:0] m32;
        logic signed [63:0] t;
        logic signed [63:0] u;
        logic [31:0]        mx;
        logic [31:0]        my;
        logic [63:0]        prod;
        logic [63:0]        sh;
        logic               qbit;

        n_state = r_state;
        n_pc    = r_pc;
        n_op    = r_op;
        n_adc   = r_adc;
        n_res   = r_res;
        n_fine  = r_fine;
        n_x     = r_x;
        n_v1    = r_v1;
        n_v2    = r_v2;
        n_w     = r_w;
        n_ma    = r_ma;
        n_mb    = r_mb;
        n_mp    = r_mp;
        n_mph   = r_mph;
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_den   = r_den;
        n_cnt   = r_cnt;
        n_qneg  = r_qneg;

        go_mul  = 1'b0;
        go_done = 1'b0;
        ma_v    = '0;
        mb_v    = '0;
        res_v   = '0;
        t       = '0;
        u       = '0;
        adc     = {44'd0, r_adc};
        tf      = esc_pkg::sx32({32'd0, r_fine});
        m32     = esc_pkg::sx32(r_mp);
        mx      = '0;
        my      = '0;
        prod    = '0;
        sh      = '0;
        qbit    = 1'b0;

        unique case (r_state)
            esc_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_op  = i_in.op;
                    n_adc = i_in.raw_reading;
                    n_pc  = '0;
                    if (i_in.op == esc_pkg::OP_TEMP || i_in.op == esc_pkg::OP_PRESS
                        || i_in.op == esc_pkg::OP_HUM) begin
                        n_state = esc_pkg::S_RUN;
                    end else begin
                        n_res   = '0;
                        n_state = esc_pkg::S_DONE;
                    end
                end
            end

            esc_pkg::S_RUN: begin
                unique case (r_op)
                    esc_pkg::OP_TEMP: begin
                        unique case (r_pc)
                            4'd0: begin
                                t    = (adc >>> 3) - ({48'd0, r_cal_temp[15:0]} <<< 1);
                                ma_v = esc_pkg::sx32(t);
                                mb_v = esc_pkg::sx16(r_cal_temp[31:16]);
                                go_mul = 1'b1;
                            end
                            4'd1: begin
                                n_v1 = m32 >>> 11;
                                t    = (adc >>> 4) - {48'd0, r_cal_temp[15:0]};
                                ma_v = esc_pkg::sx32(t);
                                mb_v = esc_pkg::sx32(t);
                                go_mul = 1'b1;
                            end
                            4'd2: begin
                                ma_v = m32 >>> 12;
                                mb_v = esc_pkg::sx16(r_cal_temp[47:32]);
                                go_mul = 1'b1;
                            end
                            4'd3: begin
                                t      = esc_pkg::sx32(r_v1 + (m32 >>> 14));
                                n_fine = t[31:0];
                                ma_v   = t;
                                mb_v   = esc_pkg::C_T_SCALE;
                                go_mul = 1'b1;
                            end
                            default: begin
                                res_v   = esc_pkg::sx32(r_mp + esc_pkg::C_T_RND) >>> 8;
                                go_done = 1'b1;
                            end
                        endcase
                    end

                    esc_pkg::OP_PRESS: begin
                        unique case (r_pc)
                            4'd0: begin
                                t      = tf - esc_pkg::C_P_TOFS;
                                n_x    = t;
                                ma_v   = t;
                                mb_v   = t;
                                go_mul = 1'b1;
                            end
                            4'd1: begin
                                n_v2   = r_mp;
                                ma_v   = r_mp;
                                mb_v   = esc_pkg::sx16(r_cal_press_b[31:16]);
                                go_mul = 1'b1;
                            end
                            4'd2: begin
                                n_w    = r_mp;
                                ma_v   = r_x;
                                mb_v   = esc_pkg::sx16(r_cal_press_b[15:0]);
                                go_mul = 1'b1;
                            end
                            4'd3: begin
                                n_w    = r_w + (r_mp <<< 17)
                                       + (esc_pkg::sx16(r_cal_press_a[63:48]) <<< 35);
                                ma_v   = r_v2;
                                mb_v   = esc_pkg::sx16(r_cal_press_a[47:32]);
                                go_mul = 1'b1;
                            end
                            4'd4: begin
                                n_v2   = r_mp >>> 8;
                                ma_v   = r_x;
                                mb_v   = esc_pkg::sx16(r_cal_press_a[31:16]);
                                go_mul = 1'b1;
                            end
                            4'd5: begin
                                ma_v   = esc_pkg::C_P_BIAS + r_v2 + (r_mp <<< 12);
                                mb_v   = {48'd0, r_cal_press_a[15:0]};
                                go_mul = 1'b1;
                            end
                            4'd6: begin
                                t    = r_mp >>> 33;
                                n_v1 = t;
                                if (t == 64'sd0) begin
                                    res_v   = '0;
                                    go_done = 1'b1;
                                end else begin
                                    u      = esc_pkg::C_P_ADC - adc;
                                    ma_v   = (u <<< 31) - r_w;
                                    mb_v   = esc_pkg::C_P_SCALE;
                                    go_mul = 1'b1;
                                end
                            end
                            4'd7: begin
                                // signed divide r_mp / r_v1 on magnitudes
                                n_qneg  = r_mp[63] ^ r_v1[63];
                                n_quo   = r_mp[63] ? 64'(-r_mp) : r_mp;
                                n_den   = r_v1[63] ? 64'(-r_v1) : r_v1;
                                n_rem   = '0;
                                n_cnt   = '0;
                                n_state = esc_pkg::S_DIV;
                            end
                            4'd8: begin
                                t      = r_qneg ? -$signed(r_quo) : $signed(r_quo);
                                n_quo  = t;
                                ma_v   = esc_pkg::sx16(r_cal_press_c);
                                mb_v   = t >>> 13;
                                go_mul = 1'b1;
                            end
                            4'd9: begin
                                ma_v   = r_mp;
                                mb_v   = $signed(r_quo) >>> 13;
                                go_mul = 1'b1;
                            end
                            4'd10: begin
                                n_v2   = r_mp >>> 25;
                                ma_v   = esc_pkg::sx16(r_cal_press_b[63:48]);
                                mb_v   = r_quo;
                                go_mul = 1'b1;
                            end
                            default: begin
                                t = ($signed(r_quo) + r_v2 + (r_mp >>> 19)) >>> 8;
                                res_v   = t + (esc_pkg::sx16(r_cal_press_b[47:32]) <<< 4);
                                go_done = 1'b1;
                            end
                        endcase
                    end

                    default: begin
                        // humidity
                        unique case (r_pc)
                            4'd0: begin
                                t      = esc_pkg::sx32(tf - esc_pkg::C_H_TOFS);
                                n_x    = t;
                                ma_v   = esc_pkg::sx16(r_cal_hum_b[31:16]);
                                mb_v   = t;
                                go_mul = 1'b1;
                            end
                            4'd1: begin
                                t    = ({48'd0, r_adc[15:0]} <<< 14)
                                     - (esc_pkg::sx16(r_cal_hum_b[15:0]) <<< 20) - r_mp;
                                n_v1 = esc_pkg::sx32(t + esc_pkg::C_H_RND1) >>> 15;
                                ma_v = r_x;
                                mb_v = {56'd0, r_cal_hum_a[31:24]};
                                go_mul = 1'b1;
                            end
                            4'd2: begin
                                n_v2   = esc_pkg::sx32((m32 >>> 11) + esc_pkg::C_H_OFS2);
                                ma_v   = r_x;
                                mb_v   = esc_pkg::sx8(r_cal_hum_a[39:32]);
                                go_mul = 1'b1;
                            end
                            4'd3: begin
                                ma_v   = m32 >>> 10;
                                mb_v   = r_v2;
                                go_mul = 1'b1;
                            end
                            4'd4: begin
                                ma_v   = esc_pkg::sx32((m32 >>> 10) + esc_pkg::C_H_OFS3);
                                mb_v   = esc_pkg::sx16(r_cal_hum_a[23:8]);
                                go_mul = 1'b1;
                            end
                            4'd5: begin
                                ma_v   = r_v1;
                                mb_v   = esc_pkg::sx32(r_mp + esc_pkg::C_H_RND2) >>> 14;
                                go_mul = 1'b1;
                            end
                            4'd6: begin
                                n_v1   = m32;
                                ma_v   = m32 >>> 15;
                                mb_v   = m32 >>> 15;
                                go_mul = 1'b1;
                            end
                            4'd7: begin
                                ma_v   = m32 >>> 7;
                                mb_v   = {56'd0, r_cal_hum_a[7:0]};
                                go_mul = 1'b1;
                            end
                            default: begin
                                t = esc_pkg::sx32(r_v1 - (m32 >>> 4));
                                priority if (t < 64'sd0) begin
                                    t = '0;
                                end else if (t > esc_pkg::C_H_MAX) begin
                                    t = esc_pkg::C_H_MAX;
                                end
                                res_v   = t >>> 12;
                                go_done = 1'b1;
                            end
                        endcase
                    end
                endcase
            end

            esc_pkg::S_MUL: begin
                // phase 0: lo*lo, 1: hi(a)*lo(b), 2: lo(a)*hi(b); cross terms land high
                unique case (r_mph)
                    2'd0:    begin mx = r_ma[31:0];  my = r_mb[31:0];  end
                    2'd1:    begin mx = r_ma[63:32]; my = r_mb[31:0];  end
                    default: begin mx = r_ma[31:0];  my = r_mb[63:32]; end
                endcase
                prod = mx * my;
                if (r_mph == 2'd0) begin
                    n_mp = prod;
                end else begin
                    n_mp = r_mp + {prod[31:0], 32'd0};
                end
                if (r_mph == 2'd2) begin
                    n_state = esc_pkg::S_RUN;
                    n_pc    = r_pc + 4'd1;
                end else begin
                    n_mph = r_mph + 2'd1;
                end
            end

            esc_pkg::S_DIV: begin
                sh = {r_rem[62:0], r_quo[63]};
                if (sh >= r_den) begin
                    sh   = sh - r_den;
                    qbit = 1'b1;
                end
                n_rem = sh;
                n_quo = {r_quo[62:0], qbit};
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    n_state = esc_pkg::S_RUN;
                    n_pc    = r_pc + 4'd1;
                end
            end

            default: begin
                // S_DONE: hold the result until the transaction completes
                if (out_acc) begin
                    n_state = esc_pkg::S_IDLE;
                end
            end
        endcase

        if (go_mul) begin
            n_ma    = ma_v;
            n_mb    = mb_v;
            n_mph   = '0;
            n_state = esc_pkg::S_MUL;
        end
        if (go_done) begin
            n_res   = res_v[31:0];
            n_state = esc_pkg::S_DONE;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= esc_pkg::S_IDLE;
            r_fine  <= '0;
            r_pc    <= '0;
            r_mph   <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_fine  <= n_fine;
            r_pc    <= n_pc;
            r_mph   <= n_mph;
            r_cnt   <= n_cnt;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_op   <= n_op;
        r_adc  <= n_adc;
        r_res  <= n_res;
        r_x    <= n_x;
        r_v1   <= n_v1;
        r_v2   <= n_v2;
        r_w    <= n_w;
        r_ma   <= n_ma;
        r_mb   <= n_mb;
        r_mp   <= n_mp;
        r_rem  <= n_rem;
        r_quo  <= n_quo;
        r_den  <= n_den;
        r_qneg <= n_qneg;
    end

    // a zero divisor must be caught before the divider starts
    `ESC_ASSERT_NEVER(a_div_nonzero, i_clk, i_rst_n, (r_state == esc_pkg::S_DIV) && (r_den == 64'd0), "divider running with zero divisor")
    // only the temperature program steps may change the fine temperature
    `ESC_ASSERT(a_fine_hold, i_clk, i_rst_n, !((r_state == esc_pkg::S_RUN) && (r_op == esc_pkg::OP_TEMP)) |=> $stable(r_fine), "fine temperature changed outside temperature step")
    // an accepted reading leaves idle
    `ESC_ASSERT(a_busy_after_accept, i_clk, i_rst_n, in_acc |=> (r_state != esc_pkg::S_IDLE), "sequencer stayed idle after accept")
    // multiplier uses only three phases
    `ESC_ASSERT_NEVER(a_mul_phase, i_clk, i_rst_n, (r_state == esc_pkg::S_MUL) && (r_mph == 2'd3), "multiplier phase out of range")

endmodule

// ----- verif/esc_result_checker.sv -----
// ----------------------------------------------------------------------------
// esc_result_checker
// Watches the calibration, reading and result channels of the compensation
// unit. It keeps its own copy of the calibration words and the fine
// temperature, predicts each result and compares it with what comes out.
// ----------------------------------------------------------------------------
module esc_result_checker
    import esc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    esc_cfg_if    cfg,
    esc_in_if     rd,
    esc_out_if    res,
    output int    o_fail_count,
    output int    o_pending
);

    typedef struct packed {
        logic [OP_W-1:0]         kind;
        logic signed [RES_W-1:0] value;
    } t_reading_result;

    logic [47:0] cal_temp;
    logic [63:0] cal_press_a;
    logic [63:0] cal_press_b;
    logic [15:0] cal_press_c;
    logic [39:0] cal_hum_a;
    logic [31:0] cal_hum_b;
    int          fine_temp;

    t_reading_result expected_results[$];
    int              mismatch_count;

    function automatic int comp_temperature(input int adc, output int tf);
        int t1, t2, t3, a, b, v1, v2;
        t1 = int'(cal_temp[15:0]);
        t2 = int'($signed(cal_temp[31:16]));
        t3 = int'($signed(cal_temp[47:32]));
        a  = (adc >>> 3) - t1 * 2;
        v1 = (a * t2) >>> 11;
        b  = (adc >>> 4) - t1;
        v2 = (((b * b) >>> 12) * t3) >>> 14;
        tf = v1 + v2;
        return (tf * 5 + 128) >>> 8;
    endfunction

    function automatic int comp_pressure(input longint adc, input longint tf);
        longint p1, p2, p3, p4, p5, p6, p7, p8, p9;
        longint v1, v2, num, q, a, b, p;
        p1 = longint'(cal_press_a[15:0]);
        p2 = longint'($signed(cal_press_a[31:16]));
        p3 = longint'($signed(cal_press_a[47:32]));
        p4 = longint'($signed(cal_press_a[63:48]));
        p5 = longint'($signed(cal_press_b[15:0]));
        p6 = longint'($signed(cal_press_b[31:16]));
        p7 = longint'($signed(cal_press_b[47:32]));
        p8 = longint'($signed(cal_press_b[63:48]));
        p9 = longint'($signed(cal_press_c));
        v1 = tf - 128000;
        v2 = v1 * v1 * p6;
        v2 = v2 + ((v1 * p5) << 17);
        v2 = v2 + (p4 << 35);
        v1 = ((v1 * v1 * p3) >>> 8) + ((v1 * p2) << 12);
        v1 = (((64'sd1 << 47) + v1) * p1) >>> 33;
        if (v1 == 0) return 0;
        p   = 1048576 - adc;
        num = ((p << 31) - v2) * 3125;
        // most negative value over -1 wraps to itself
        if (num == 64'sh8000_0000_0000_0000 && v1 == -1) q = num;
        else q = num / v1;
        a = ((p9 * (q >>> 13)) * (q >>> 13)) >>> 25;
        b = (p8 * q) >>> 19;
        p = ((q + a + b) >>> 8) + (p7 << 4);
        return int'(p[31:0]);
    endfunction

    function automatic int comp_humidity(input int adc, input int tf);
        int h1, h2, h3, h4, h5, h6, x, t1, t2, v, s;
        h1 = int'(cal_hum_a[7:0]);
        h2 = int'($signed(cal_hum_a[23:8]));
        h3 = int'(cal_hum_a[31:24]);
        h6 = int'($signed(cal_hum_a[39:32]));
        h4 = int'($signed(cal_hum_b[15:0]));
        h5 = int'($signed(cal_hum_b[31:16]));
        x  = tf - 76800;
        t1 = (adc << 14) - (h4 << 20) - h5 * x;
        t1 = (t1 + 16384) >>> 15;
        t2 = ((x * h3) >>> 11) + 32768;
        t2 = (((x * h6) >>> 10) * t2) >>> 10;
        t2 = ((t2 + 2097152) * h2 + 8192) >>> 14;
        v  = t1 * t2;
        s  = v >>> 15;
        v  = v - ((((s * s) >>> 7) * h1) >>> 4);
        if (v < 0) v = 0;
        if (v > 419430400) v = 419430400;
        return v >>> 12;
    endfunction

    assign o_pending = expected_results.size();

    always @(posedge i_clk) begin
        t_reading_result exp_r;
        int tf_new;
        if (!i_rst_n) begin
            cal_temp       <= '0;
            cal_press_a    <= '0;
            cal_press_b    <= '0;
            cal_press_c    <= '0;
            cal_hum_a      <= '0;
            cal_hum_b      <= '0;
            fine_temp      <= 0;
            o_fail_count   <= 0;
            mismatch_count = 0;
            expected_results.delete();
        end else begin
            if (cfg.valid && cfg.ready) begin
                case (cfg.index)
                    CFG_CAL_TEMP:    cal_temp    <= cfg.data[47:0];
                    CFG_CAL_PRESS_A: cal_press_a <= cfg.data;
                    CFG_CAL_PRESS_B: cal_press_b <= cfg.data;
                    CFG_CAL_PRESS_C: cal_press_c <= cfg.data[15:0];
                    CFG_CAL_HUM_A:   cal_hum_a   <= cfg.data[39:0];
                    CFG_CAL_HUM_B:   cal_hum_b   <= cfg.data[31:0];
                    default: ;
                endcase
            end
            if (rd.valid && rd.ready) begin
                exp_r.kind = rd.op;
                case (rd.op)
                    OP_TEMP: begin
                        exp_r.value = comp_temperature(int'(rd.raw_reading), tf_new);
                        fine_temp <= tf_new;
                    end
                    OP_PRESS: exp_r.value = comp_pressure(longint'(rd.raw_reading),
                                                          longint'(fine_temp));
                    OP_HUM:   exp_r.value = comp_humidity(int'(rd.raw_reading[15:0]),
                                                          fine_temp);
                    default:  exp_r.value = '0;
                endcase
                expected_results.push_back(exp_r);
            end
            if (res.valid && res.ready) begin
                if (expected_results.size() == 0) begin
                    o_fail_count <= o_fail_count + 1;
                    if (mismatch_count < 10)
                        $display("unexpected result: kind %0d value %0d",
                                 res.kind, res.compensated);
                    mismatch_count++;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (res.kind !== exp_r.kind || res.compensated !== exp_r.value) begin
                        o_fail_count <= o_fail_count + 1;
                        if (mismatch_count < 10)
                            $display("mismatch: expected kind %0d value %0d, got kind %0d value %0d",
                                     exp_r.kind, exp_r.value, res.kind, res.compensated);
                        mismatch_count++;
                    end
                end
            end
        end
    end

endmodule

// ----- verif/tb_env_sensor_compensation_unit.sv -----
// ----------------------------------------------------------------------------
// tb_env_sensor_compensation_unit
// Drives calibration phases and readings into the compensation unit under
// bursty input and a stalling receiver; a checker beside the block predicts
// and compares every result transaction.
// ----------------------------------------------------------------------------
module tb_env_sensor_compensation_unit;
    import esc_pkg::*;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   burst_left;   // transactions left in the current sender burst
    int   stall_mode;   // receiver behavior for the current phase

    esc_cfg_if cfg_if();
    esc_in_if  in_if();
    esc_out_if res_if();

    env_sensor_compensation_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_in    (in_if),
        .o_res   (res_if)
    );

    esc_result_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .cfg          (cfg_if),
        .rd           (in_if),
        .res          (res_if),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop: roughly 800 readings in all, plus gaps and stalls, finish
    // far below this bound.
    initial begin
        #20_000_000;
        $display("env_sensor_compensation_unit test failed");
        $finish;
    end

    // Receiver: mode 0 always ready, 1 light random stalls, 2 heavy stalls,
    // 3 periodic pattern of long stalls.
    always @(negedge i_clk) begin
        case (stall_mode)
            0:       res_if.ready <= 1'b1;
            1:       res_if.ready <= ($urandom_range(0, 3) != 0);
            2:       res_if.ready <= ($urandom_range(0, 3) == 0);
            default: res_if.ready <= (($time / 10) % 23) > 15;
        endcase
    end

    // Calibration write: one transaction on the config channel; valid is
    // left high so writes can follow back to back.
    task automatic write_cal(input logic [CIDX_W-1:0] idx, input logic [63:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        do @(posedge i_clk); while (!cfg_if.ready);
        @(negedge i_clk);
    endtask

    // One reading transaction; valid stays high across a burst and drops
    // only when a gap is inserted.
    task automatic send_reading(input logic [OP_W-1:0] op, input logic [RAW_W-1:0] raw);
        int gap;
        in_if.valid       <= 1'b1;
        in_if.op          <= op;
        in_if.raw_reading <= raw;
        do @(posedge i_clk); while (!in_if.ready);
        @(negedge i_clk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 6);
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40);
            if (gap > 0) begin
                in_if.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
    endtask

    // Stop sending and drain all outstanding results so the block is idle
    // before calibration changes.
    task automatic drain_results();
        in_if.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    // Load all six calibration words, plus a dropped write above the map.
    task automatic load_cal(input logic [47:0] ct, input logic [63:0] pa,
                            input logic [63:0] pb, input logic [15:0] pc,
                            input logic [39:0] ha, input logic [31:0] hb);
        write_cal(CFG_CAL_TEMP,    {16'hFFFF, ct});
        write_cal(CFG_CAL_PRESS_A, pa);
        write_cal(CFG_CAL_PRESS_B, pb);
        write_cal(CFG_CAL_PRESS_C, {48'hFFFF_FFFF_FFFF, pc});
        write_cal(CFG_CAL_HUM_A,   {24'hFF_FFFF, ha});
        write_cal(CFG_CAL_HUM_B,   {32'hFFFF_FFFF, hb});
        write_cal(CIDX_W'(6 + $urandom_range(0, 1)), {$urandom, $urandom});
        cfg_if.valid <= 1'b0;
    endtask

    // Sequences of a temperature reading followed by three pressure/humidity
    // readings, realistic values when asked; occasional noise and undefined ops.
    task automatic random_readings(input int count, input bit realistic);
        logic [OP_W-1:0] op;
        logic [RAW_W-1:0] raw;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 9) == 0) begin
                op  = OP_W'($urandom_range(0, 3));
                raw = RAW_W'($urandom);
            end else begin
                case (n % 4)
                    0:       op = OP_TEMP;
                    default: op = $urandom_range(0, 1) ? OP_PRESS : OP_HUM;
                endcase
                if (realistic && op == OP_TEMP)
                    raw = RAW_W'($urandom_range(400000, 600000));
                else if (realistic && op == OP_PRESS)
                    raw = RAW_W'($urandom_range(250000, 450000));
                else if (realistic)
                    raw = {4'($urandom), 16'($urandom_range(20000, 40000))};
                else
                    raw = RAW_W'($urandom);
            end
            send_reading(op, raw);
        end
    endtask

    initial begin
        i_rst_n           = 1'b0;
        cfg_if.valid      = 1'b0;
        cfg_if.index      = '0;
        cfg_if.data       = '0;
        in_if.valid       = 1'b0;
        in_if.op          = OP_TEMP;
        in_if.raw_reading = '0;
        res_if.ready      = 1'b0;
        stall_mode        = 0;
        burst_left        = 0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: reset calibration (all zero), so pressure divisor is zero.
        send_reading(OP_PRESS, '0);
        send_reading(OP_HUM, '0);
        send_reading(OP_TEMP, '0);

        // Typical calibration set; field extremes and every op.
        drain_results();
        load_cal({16'hFC18, 16'd26435, 16'd27504},
                 {16'd2855, 16'd3024, 16'hD643, 16'd36477},
                 {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140},
                 16'd6000,
                 {8'd30, 8'd0, 16'd362, 8'd75},
                 {16'd50, 16'd313});
        send_reading(OP_TEMP, 20'd519888);
        send_reading(OP_PRESS, 20'd415148);
        send_reading(OP_HUM, 20'd28000);
        send_reading(OP_HUM, 20'hF6D60);    // upper bits ignored for humidity
        send_reading(OP_PRESS, '0);
        send_reading(OP_PRESS, 20'hFFFFF);
        send_reading(OP_HUM, '0);           // clamps low
        send_reading(OP_HUM, 20'h0FFFF);    // clamps high
        send_reading(2'd3, 20'hFFFFF);      // undefined op
        send_reading(OP_TEMP, 20'hFFFFF);
        send_reading(OP_PRESS, 20'd300000);
        send_reading(OP_TEMP, '0);
        send_reading(OP_PRESS, 20'd300000);
        send_reading(OP_HUM, 20'd30000);

        // All-ones calibration: every coefficient at its bit extreme.
        drain_results();
        stall_mode = 2;
        load_cal('1, '1, '1, '1, '1, '1);
        send_reading(OP_TEMP, 20'hFFFFF);
        send_reading(OP_PRESS, 20'hFFFFF);
        send_reading(OP_HUM, 20'hFFFFF);
        send_reading(OP_TEMP, '0);
        send_reading(OP_PRESS, '0);
        send_reading(OP_HUM, '0);

        // Random phases: realistic and random calibrations, varied stalls.
        for (int ph = 0; ph < 8; ph++) begin
            drain_results();
            stall_mode = ph % 4;
            if (ph % 2 == 0)
                load_cal({16'($urandom_range(0, 2000) - 1000), 16'($urandom_range(25000, 28000)),
                          16'($urandom_range(27000, 28000))},
                         {16'($urandom_range(2000, 9000)), 16'($urandom_range(2000, 5000)),
                          16'(-$urandom_range(9000, 12000)), 16'($urandom_range(30000, 40000))},
                         {16'(-$urandom_range(14000, 15000)), 16'($urandom_range(10000, 16000)),
                          16'(-$urandom_range(1, 20)), 16'($urandom_range(0, 300))},
                         16'($urandom_range(4000, 7000)),
                         {8'($urandom_range(0, 40)), 8'($urandom_range(0, 5)),
                          16'($urandom_range(300, 400)), 8'($urandom_range(0, 100))},
                         {16'($urandom_range(0, 60)), 16'($urandom_range(250, 400))});
            else
                load_cal(48'({$urandom, $urandom}), {$urandom, $urandom},
                         {$urandom, $urandom}, 16'($urandom),
                         40'({$urandom, $urandom}), $urandom);
            random_readings(95, ph % 2 == 0);
        end

        drain_results();
        repeat (150) @(negedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("env_sensor_compensation_unit test passed");
        else
            $display("env_sensor_compensation_unit test failed");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/esc_pkg.sv
rtl/esc_if.sv
rtl/env_sensor_compensation_unit.sv
verif/esc_result_checker.sv
verif/tb_env_sensor_compensation_unit.sv
